>>> hdl/fzph_pkg.sv
// ----------------------------------------------------------------------------
// fzph_pkg
// Shared types, codes and fuzzy set tables for the fuzzy pH pulse controller.
// ----------------------------------------------------------------------------
`default_nettype none

package fzph_pkg;

   // default sizing
   localparam int SAMPLE_POINTS_DEF = 71;
   localparam int RULE_COUNT_DEF    = 5;
   localparam int TABLE_RULES       = 5;

   // Q1.12 membership
   localparam int Q12_ONE = 4096;
   localparam int ONE_W   = 13;

   // error path
   localparam int ERR_W        = 17;
   localparam int E_W          = 12;
   localparam int UNIVERSE_TOP = 3277;

   // reciprocal ramp divide: floor(dist*4096/span) = (dist*RECIP) >> RECIP_SHIFT
   localparam int DIST_W      = 10;
   localparam int RECIP_SHIFT = 24;
   localparam int RECIP_W     = 29;
   localparam longint RECIP_NUM = 64'd1 << (RECIP_SHIFT + 12);

   // final scaling and divider
   localparam int GAIN_SCALE = 10000;   // 10 tenths-to-s times 1000 ms
   localparam int GK_W       = 26;
   localparam int OUT_FRAC   = 256;     // Q4.8 gain
   localparam int Q_W        = 18;

   // register interface
   localparam int PADDR_W = 4;
   localparam int PDATA_W = 32;
   localparam logic [1:0] REG_DEADBAND   = 2'd0;
   localparam logic [1:0] REG_SATURATION = 2'd1;
   localparam logic [1:0] REG_GAIN       = 2'd2;
   localparam logic [1:0] REG_MAX_PULSE  = 2'd3;

   localparam logic [12:0] DEADBAND_RST   = 13'd410;
   localparam logic [13:0] SATURATION_RST = 14'd3277;
   localparam logic [11:0] GAIN_RST       = 12'd512;
   localparam logic [15:0] MAX_PULSE_RST  = 16'd20000;

   // result zones
   localparam logic [1:0] ZONE_DEAD  = 2'd0;
   localparam logic [1:0] ZONE_FUZZY = 2'd1;
   localparam logic [1:0] ZONE_SAT   = 2'd2;

   // input sets, 1/4096 pH
   localparam logic [E_W-1:0] IN_P0 [TABLE_RULES] =
      '{12'd0, 12'd164, 12'd901, 12'd1720, 12'd2662};
   localparam logic [E_W-1:0] IN_P1 [TABLE_RULES] =
      '{12'd0, 12'd614, 12'd1434, 12'd2376, 12'd3277};
   localparam logic [E_W-1:0] IN_P2 [TABLE_RULES] =
      '{12'd246, 12'd1147, 12'd2048, 12'd3072, 12'd3277};
   localparam logic [E_W-1:0] IN_P3 [TABLE_RULES] =
      '{12'd0, 12'd0, 12'd0, 12'd0, 12'd3277};
   localparam logic IN_TRAP [TABLE_RULES] = '{1'b0, 1'b0, 1'b0, 1'b0, 1'b1};

   // reciprocals of the rising ramp spans (b-a); zero where the edge is flat
   localparam logic [RECIP_W-1:0] IN_RU [TABLE_RULES] = '{
      '0,
      RECIP_W'((RECIP_NUM + 64'd449) / 64'd450),
      RECIP_W'((RECIP_NUM + 64'd532) / 64'd533),
      RECIP_W'((RECIP_NUM + 64'd655) / 64'd656),
      RECIP_W'((RECIP_NUM + 64'd614) / 64'd615)
   };
   // reciprocals of the falling ramp spans (c-b for triangles, d-c for trapezoids)
   localparam logic [RECIP_W-1:0] IN_RD [TABLE_RULES] = '{
      RECIP_W'((RECIP_NUM + 64'd245) / 64'd246),
      RECIP_W'((RECIP_NUM + 64'd532) / 64'd533),
      RECIP_W'((RECIP_NUM + 64'd613) / 64'd614),
      RECIP_W'((RECIP_NUM + 64'd695) / 64'd696),
      '0
   };

   // output sets, tenths of a second
   localparam int OUT_P0 [TABLE_RULES] = '{0, 30, 55, 75, 95};
   localparam int OUT_P1 [TABLE_RULES] = '{0, 50, 70, 90, 100};
   localparam int OUT_P2 [TABLE_RULES] = '{15, 70, 90, 100, 100};
   localparam int OUT_P3 [TABLE_RULES] = '{0, 0, 0, 0, 100};
   localparam logic OUT_TRAP [TABLE_RULES] = '{1'b0, 1'b0, 1'b0, 1'b0, 1'b1};

   typedef struct packed {
      logic [15:0] ph_target;
      logic [15:0] ph_measured;
   } req_type;

   typedef struct packed {
      logic [15:0] pulse_ms;
      logic [1:0]  zone;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_EVAL,
      ST_GRADE,
      ST_SWEEP,
      ST_PREP,
      ST_MUL,
      ST_DINIT,
      ST_DIV,
      ST_CLAMP,
      ST_RESULT
   } fzph_state_type;

endpackage

`default_nettype wire

>>> hdl/fuzzy_ph_pulse_controller.sv
// ----------------------------------------------------------------------------
// fuzzy_ph_pulse_controller
// Mamdani fuzzy controller that turns a pH error (setpoint minus measured,
// 1/4096 pH) into a pump pulse length in ms. Errors at or below the dead
// band give a zero pulse, errors at or above the saturation threshold give
// max_pulse_ms, and errors in between run five min/max rules and a centroid
// over SAMPLE_POINTS output samples, scaled by the Q4.8 gain and clamped.
// One word is in work at a time and req_ready is low meanwhile. A dead band
// or saturated word goes from ST_EVAL straight to ST_RESULT; a fuzzy word
// passes through ST_GRADE, ST_SWEEP and the divider states instead:
// one cycle per rule through a shared reciprocal multiplier,
// one cycle per output sample through the aggregation and multiply-
// accumulate path, then an 18-step shift-subtract divider for the centroid.
// A finished result waits in the output register while the next word is
// taken. Registers sit at byte addresses 0, 4, 8, 12 and are to be written
// only while the block is idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
`default_nettype none

module fuzzy_ph_pulse_controller #(
   parameter int SAMPLE_POINTS = fzph_pkg::SAMPLE_POINTS_DEF,
   parameter int RULE_COUNT    = fzph_pkg::RULE_COUNT_DEF
) (
   input  wire                             clock,
   input  wire                             reset,
   // input words
   input  wire                             req_valid,
   output logic                            req_ready,
   input  fzph_pkg::req_type               req_data,
   // result words
   output logic                            rsp_valid,
   input  wire                             rsp_ready,
   output fzph_pkg::rsp_type               rsp_data,
   // register port
   input  wire                             psel,
   input  wire                             penable,
   input  wire                             pwrite,
   input  wire  [fzph_pkg::PADDR_W-1:0]    paddr,
   input  wire  [fzph_pkg::PDATA_W-1:0]    pwdata,
   output logic [fzph_pkg::PDATA_W-1:0]    prdata,
   output logic                            pready
);

   localparam int NRULES  = (RULE_COUNT < fzph_pkg::TABLE_RULES) ?
                            RULE_COUNT : fzph_pkg::TABLE_RULES;
   localparam int STEPS   = SAMPLE_POINTS - 1;
   localparam int RIDX_W  = $clog2(NRULES);
   localparam int SIDX_W  = $clog2(SAMPLE_POINTS);
   localparam int CNT_W   = ($clog2(SAMPLE_POINTS + 1) > 5) ?
                            $clog2(SAMPLE_POINTS + 1) : 5;
   localparam int ONE_W   = fzph_pkg::ONE_W;
   localparam int WSUM_W  = $clog2(fzph_pkg::Q12_ONE * SAMPLE_POINTS *
                                   (SAMPLE_POINTS - 1) / 2 + 1);
   localparam int MSUM_W  = $clog2(fzph_pkg::Q12_ONE * SAMPLE_POINTS + 1);
   localparam int DEN_SCALE = STEPS * fzph_pkg::OUT_FRAC;
   localparam int DEN_W   = MSUM_W + $clog2(DEN_SCALE + 1);
   localparam int GK_W    = fzph_pkg::GK_W;
   localparam int NUM_W   = WSUM_W + GK_W;
   localparam int DVD_W   = NUM_W + 2;
   localparam int DIV_W   = DEN_W + 1;
   localparam int REM_W   = DIV_W + 1;
   localparam int Q_W     = fzph_pkg::Q_W;
   localparam int E_W     = fzph_pkg::E_W;
   localparam int ERR_W   = fzph_pkg::ERR_W;
   localparam int PROD_W  = fzph_pkg::DIST_W + fzph_pkg::RECIP_W;

   // ------------------------------------------------------------------------
   // output membership table, one entry per sample and rule
   // ------------------------------------------------------------------------
   logic [ONE_W-1:0] og_tab [SAMPLE_POINTS][NRULES];

   for (genvar gi = 0; gi < SAMPLE_POINTS; gi++) begin : g_samp
      for (genvar gr = 0; gr < NRULES; gr++) begin : g_rule
         localparam longint ONE = fzph_pkg::Q12_ONE;
         localparam longint V   = longint'(gi) * 100;
         localparam longint A   = longint'(fzph_pkg::OUT_P0[gr]) * STEPS;
         localparam longint B   = longint'(fzph_pkg::OUT_P1[gr]) * STEPS;
         localparam longint C   = longint'(fzph_pkg::OUT_P2[gr]) * STEPS;
         localparam longint D   = longint'(fzph_pkg::OUT_P3[gr]) * STEPS;
         localparam longint UP_SPAN  = (B > A) ? B - A : 1;
         localparam longint TDN_SPAN = (C > B) ? C - B : 1;
         localparam longint ZDN_SPAN = (D > C) ? D - C : 1;
         localparam longint TRI_G =
            (V == B) ? ONE :
            (B != C && B < V && V < C) ? (C - V) * ONE / TDN_SPAN :
            (A != B && A < V && V < B) ? (V - A) * ONE / UP_SPAN : 0;
         localparam longint UP_G = (V >= B) ? ONE : (V < A) ? 0 :
                                   (V - A) * ONE / UP_SPAN;
         localparam longint DN_G = (V <= C) ? ONE : (V > D) ? 0 :
                                   (D - V) * ONE / ZDN_SPAN;
         localparam longint OG = fzph_pkg::OUT_TRAP[gr] ?
                                 ((UP_G < DN_G) ? UP_G : DN_G) : TRI_G;
         assign og_tab[gi][gr] = ONE_W'(OG);
      end
   end

   // ------------------------------------------------------------------------
   // registers
   // ------------------------------------------------------------------------
   fzph_pkg::fzph_state_type state_ff, state_in;
   logic [CNT_W-1:0]         cnt_ff, cnt_in;
   logic signed [ERR_W-1:0]  err_ff, err_in;
   logic [E_W-1:0]           e_ff, e_in;
   logic [ONE_W-1:0]         grade_ff [NRULES];
   logic [ONE_W-1:0]         grade_in [NRULES];
   logic [ONE_W-1:0]         agg_ff, agg_in;
   logic [SIDX_W-1:0]        aidx_ff, aidx_in;
   logic [WSUM_W-1:0]        wsum_ff, wsum_in;
   logic [MSUM_W-1:0]        msum_ff, msum_in;
   logic [GK_W-1:0]          gk_ff, gk_in;
   logic [DEN_W-1:0]         den_ff, den_in;
   logic [NUM_W-1:0]         num_ff, num_in;
   logic [REM_W-1:0]         rem_ff, rem_in;
   logic [Q_W-1:0]           lo_ff, lo_in;
   logic [Q_W-1:0]           q_ff, q_in;
   logic [15:0]              res_pulse_ff, res_pulse_in;
   logic [1:0]               res_zone_ff, res_zone_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   fzph_pkg::rsp_type        rsp_data_ff, rsp_data_in;

   logic [12:0]              deadband_ff;
   logic [13:0]              saturation_ff;
   logic [11:0]              gain_ff;
   logic [15:0]              max_pulse_ff;

   // ------------------------------------------------------------------------
   // register port
   // ------------------------------------------------------------------------
   logic       csr_wr;
   logic [1:0] csr_idx;

   assign pready  = 1'b1;
   assign csr_wr  = psel & penable & pwrite;
   assign csr_idx = paddr[3:2];

   always_comb begin
      case (csr_idx)
         fzph_pkg::REG_DEADBAND:   prdata = fzph_pkg::PDATA_W'(deadband_ff);
         fzph_pkg::REG_SATURATION: prdata = fzph_pkg::PDATA_W'(saturation_ff);
         fzph_pkg::REG_GAIN:       prdata = fzph_pkg::PDATA_W'(gain_ff);
         fzph_pkg::REG_MAX_PULSE:  prdata = fzph_pkg::PDATA_W'(max_pulse_ff);
         default:                  prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         deadband_ff   <= fzph_pkg::DEADBAND_RST;
         saturation_ff <= fzph_pkg::SATURATION_RST;
         gain_ff       <= fzph_pkg::GAIN_RST;
         max_pulse_ff  <= fzph_pkg::MAX_PULSE_RST;
      end else if (csr_wr) begin
         case (csr_idx)
            fzph_pkg::REG_DEADBAND:   deadband_ff   <= pwdata[12:0];
            fzph_pkg::REG_SATURATION: saturation_ff <= pwdata[13:0];
            fzph_pkg::REG_GAIN:       gain_ff       <= pwdata[11:0];
            fzph_pkg::REG_MAX_PULSE:  max_pulse_ff  <= pwdata[15:0];
            default: ;
         endcase
      end
   end

   // ------------------------------------------------------------------------
   // input grade unit: one rule per cycle, ramp divide by reciprocal
   // ------------------------------------------------------------------------
   logic [RIDX_W-1:0]             rsel;
   logic [E_W-1:0]                pa, pb, pc, pd;
   logic                          g_full, g_ramp, g_up;
   logic [fzph_pkg::DIST_W-1:0]   ramp_dist;
   logic [fzph_pkg::RECIP_W-1:0]  recip;
   logic [PROD_W-1:0]             gprod;
   logic [ONE_W-1:0]              grade_c;

   assign rsel = cnt_ff[RIDX_W-1:0];
   assign pa   = fzph_pkg::IN_P0[rsel];
   assign pb   = fzph_pkg::IN_P1[rsel];
   assign pc   = fzph_pkg::IN_P2[rsel];
   assign pd   = fzph_pkg::IN_P3[rsel];

   always_comb begin
      g_full = 1'b0;
      g_ramp = 1'b0;
      g_up   = 1'b0;
      if (!fzph_pkg::IN_TRAP[rsel]) begin
         if (e_ff == pb) begin
            g_full = 1'b1;
         end else if (pa != pb && pa < e_ff && e_ff < pb) begin
            g_ramp = 1'b1;
            g_up   = 1'b1;
         end else if (pb != pc && pb < e_ff && e_ff < pc) begin
            g_ramp = 1'b1;
         end
      end else begin
         if (e_ff >= pb && e_ff <= pc) begin
            g_full = 1'b1;
         end else if (e_ff < pa || e_ff > pd) begin
            g_full = 1'b0;
         end else if (e_ff < pb) begin
            g_ramp = 1'b1;
            g_up   = 1'b1;
         end else begin
            g_ramp = 1'b1;
         end
      end
   end

   // falling edge of a trapezoid runs to d, of a triangle to c
   assign ramp_dist = g_up ? fzph_pkg::DIST_W'(e_ff - pa) :
                      fzph_pkg::IN_TRAP[rsel] ? fzph_pkg::DIST_W'(pd - e_ff) :
                      fzph_pkg::DIST_W'(pc - e_ff);
   assign recip = g_up ? fzph_pkg::IN_RU[rsel] : fzph_pkg::IN_RD[rsel];
   assign gprod = PROD_W'(ramp_dist) * PROD_W'(recip);
   assign grade_c = g_full ? ONE_W'(fzph_pkg::Q12_ONE) :
                    g_ramp ? gprod[fzph_pkg::RECIP_SHIFT +: ONE_W] : '0;

   // ------------------------------------------------------------------------
   // aggregation of one output sample: max over rules of min(fire, set)
   // ------------------------------------------------------------------------
   logic [SIDX_W-1:0] sidx;
   logic [ONE_W-1:0]  agg_c;

   assign sidx = (cnt_ff < CNT_W'(SAMPLE_POINTS)) ? cnt_ff[SIDX_W-1:0] : '0;

   always_comb begin
      logic [ONE_W-1:0] fire;
      agg_c = '0;
      for (int r = 0; r < NRULES; r++) begin
         fire = (grade_ff[r] < og_tab[sidx][r]) ? grade_ff[r] : og_tab[sidx][r];
         if (fire > agg_c) begin
            agg_c = fire;
         end
      end
   end

   // ------------------------------------------------------------------------
   // divider step and dividend
   // ------------------------------------------------------------------------
   logic [DVD_W-1:0] dvd_c;
   logic [REM_W-1:0] rem_sh;
   logic [REM_W-1:0] dsr;
   logic             q_bit;

   assign dvd_c  = DVD_W'({num_ff, 1'b0}) + DVD_W'(den_ff);
   assign dsr    = REM_W'({den_ff, 1'b0});
   assign rem_sh = {rem_ff[REM_W-2:0], lo_ff[Q_W-1]};
   assign q_bit  = (rem_sh >= dsr);

   // ------------------------------------------------------------------------
   // sequencer
   // ------------------------------------------------------------------------
   assign req_ready = (state_ff == fzph_pkg::ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      err_in       = err_ff;
      e_in         = e_ff;
      grade_in     = grade_ff;
      agg_in       = agg_ff;
      aidx_in      = aidx_ff;
      wsum_in      = wsum_ff;
      msum_in      = msum_ff;
      gk_in        = gk_ff;
      den_in       = den_ff;
      num_in       = num_ff;
      rem_in       = rem_ff;
      lo_in        = lo_ff;
      q_in         = q_ff;
      res_pulse_in = res_pulse_ff;
      res_zone_in  = res_zone_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      rsp_data_in  = rsp_data_ff;

      case (state_ff)
         fzph_pkg::ST_IDLE: begin
            if (req_valid) begin
               err_in   = $signed({1'b0, req_data.ph_target}) -
                          $signed({1'b0, req_data.ph_measured});
               state_in = fzph_pkg::ST_EVAL;
            end
         end

         fzph_pkg::ST_EVAL: begin
            cnt_in = '0;
            if (err_ff <= $signed({4'b0, deadband_ff})) begin
               res_pulse_in = '0;
               res_zone_in  = fzph_pkg::ZONE_DEAD;
               state_in     = fzph_pkg::ST_RESULT;
            end else if (err_ff >= $signed({3'b0, saturation_ff})) begin
               res_pulse_in = max_pulse_ff;
               res_zone_in  = fzph_pkg::ZONE_SAT;
               state_in     = fzph_pkg::ST_RESULT;
            end else begin
               e_in = (err_ff > ERR_W'(fzph_pkg::UNIVERSE_TOP)) ?
                      E_W'(fzph_pkg::UNIVERSE_TOP) : err_ff[E_W-1:0];
               state_in = fzph_pkg::ST_GRADE;
            end
         end

         fzph_pkg::ST_GRADE: begin
            grade_in[rsel] = grade_c;
            if (cnt_ff == CNT_W'(NRULES - 1)) begin
               cnt_in   = '0;
               wsum_in  = '0;
               msum_in  = '0;
               state_in = fzph_pkg::ST_SWEEP;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end

         // sample cnt is aggregated while sample cnt-1 is accumulated
         fzph_pkg::ST_SWEEP: begin
            agg_in  = agg_c;
            aidx_in = sidx;
            if (cnt_ff != '0) begin
               wsum_in = wsum_ff + WSUM_W'(aidx_ff) * WSUM_W'(agg_ff);
               msum_in = msum_ff + MSUM_W'(agg_ff);
            end
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(SAMPLE_POINTS)) begin
               state_in = fzph_pkg::ST_PREP;
            end
         end

         fzph_pkg::ST_PREP: begin
            gk_in  = GK_W'(gain_ff) * GK_W'(fzph_pkg::GAIN_SCALE);
            den_in = DEN_W'(msum_ff) * DEN_W'(DEN_SCALE);
            if (msum_ff == '0) begin
               res_pulse_in = '0;
               res_zone_in  = fzph_pkg::ZONE_FUZZY;
               state_in     = fzph_pkg::ST_RESULT;
            end else begin
               state_in = fzph_pkg::ST_MUL;
            end
         end

         fzph_pkg::ST_MUL: begin
            num_in   = NUM_W'(wsum_ff) * NUM_W'(gk_ff);
            state_in = fzph_pkg::ST_DINIT;
         end

         // quotient is known to fit Q_W bits, so the top part starts below
         // the divisor
         fzph_pkg::ST_DINIT: begin
            rem_in   = REM_W'(dvd_c >> Q_W);
            lo_in    = dvd_c[Q_W-1:0];
            q_in     = '0;
            cnt_in   = '0;
            state_in = fzph_pkg::ST_DIV;
         end

         fzph_pkg::ST_DIV: begin
            rem_in = q_bit ? rem_sh - dsr : rem_sh;
            q_in   = {q_ff[Q_W-2:0], q_bit};
            lo_in  = {lo_ff[Q_W-2:0], 1'b0};
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(Q_W - 1)) begin
               state_in = fzph_pkg::ST_CLAMP;
            end
         end

         fzph_pkg::ST_CLAMP: begin
            res_pulse_in = (q_ff > Q_W'(max_pulse_ff)) ? max_pulse_ff : q_ff[15:0];
            res_zone_in  = fzph_pkg::ZONE_FUZZY;
            state_in     = fzph_pkg::ST_RESULT;
         end

         fzph_pkg::ST_RESULT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in         = 1'b1;
               rsp_data_in.pulse_ms = res_pulse_ff;
               rsp_data_in.zone     = res_zone_ff;
               state_in             = fzph_pkg::ST_IDLE;
            end
         end

         default: begin
            state_in = fzph_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= fzph_pkg::ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      err_ff       <= err_in;
      e_ff         <= e_in;
      grade_ff     <= grade_in;
      agg_ff       <= agg_in;
      aidx_ff      <= aidx_in;
      wsum_ff      <= wsum_in;
      msum_ff      <= msum_in;
      gk_ff        <= gk_in;
      den_ff       <= den_in;
      num_ff       <= num_in;
      rem_ff       <= rem_in;
      lo_ff        <= lo_in;
      q_ff         <= q_in;
      res_pulse_ff <= res_pulse_in;
      res_zone_ff  <= res_zone_in;
      rsp_data_ff  <= rsp_data_in;
   end

`ifndef NO_ASSERTIONS
   a_zone_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_data_ff.zone == fzph_pkg::ZONE_DEAD ||
                        rsp_data_ff.zone == fzph_pkg::ZONE_FUZZY ||
                        rsp_data_ff.zone == fzph_pkg::ZONE_SAT))
      else $error("result zone code out of range");

   a_dead_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff.zone == fzph_pkg::ZONE_DEAD) |->
      (rsp_data_ff.pulse_ms == '0))
      else $error("dead band word with nonzero pulse");

   a_sweep_clear: assert property (@(posedge clock) disable iff (reset)
      (state_ff == fzph_pkg::ST_SWEEP && cnt_ff == '0) |->
      (wsum_ff == '0 && msum_ff == '0))
      else $error("centroid sums not cleared at sweep start");

   a_rem_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == fzph_pkg::ST_DIV) |-> (rem_ff < dsr))
      else $error("divider remainder not below divisor");

   a_rsp_src: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == fzph_pkg::ST_RESULT))
      else $error("result word raised outside result state");
`endif

endmodule

`default_nettype wire

>>> tb/sv/tb_fuzzy_ph_pulse_controller.sv
// ----------------------------------------------------------------------------
// tb_fuzzy_ph_pulse_controller
// Self-checking bench for the fuzzy pH pulse controller. Words are driven
// in random bursts against a randomly stalling receiver. Each accepted word is
// scored against a bit-true predictor of the dead band / saturation / Mamdani
// centroid path. Register settings change between phases once the block has
// drained, and every register write is read back.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_fuzzy_ph_pulse_controller;
   timeunit 1ns;
   timeprecision 1ps;

   // fuzzy tables: error sets in 1/4096 pH, pulse sets in tenths of a second
   localparam int NUM_RULES   = 5;
   localparam int NUM_SAMPLES = 71;
   localparam int GRADE_ONE   = 4096;
   localparam int ERR_TOP     = 3277;
   localparam int ERR_A   [NUM_RULES] = '{0, 164, 901, 1720, 2662};
   localparam int ERR_B   [NUM_RULES] = '{0, 614, 1434, 2376, 3277};
   localparam int ERR_C   [NUM_RULES] = '{246, 1147, 2048, 3072, 3277};
   localparam int ERR_D   [NUM_RULES] = '{0, 0, 0, 0, 3277};
   localparam int PULSE_A [NUM_RULES] = '{0, 30, 55, 75, 95};
   localparam int PULSE_B [NUM_RULES] = '{0, 50, 70, 90, 100};
   localparam int PULSE_C [NUM_RULES] = '{15, 70, 90, 100, 100};
   localparam int PULSE_D [NUM_RULES] = '{0, 0, 0, 0, 100};

   typedef struct packed {
      fzph_pkg::req_type word;
      fzph_pkg::rsp_type want;
   } pending_type;

   logic                           clock = 1'b0;
   logic                           reset;
   logic                           req_valid;
   logic                           req_ready;
   fzph_pkg::req_type              req_data;
   logic                           rsp_valid;
   logic                           rsp_ready = 1'b0;
   fzph_pkg::rsp_type              rsp_data;
   logic                           psel;
   logic                           penable;
   logic                           pwrite;
   logic [fzph_pkg::PADDR_W-1:0]   paddr;
   logic [fzph_pkg::PDATA_W-1:0]   pwdata;
   logic [fzph_pkg::PDATA_W-1:0]   prdata;
   logic                           pready;

   // register copies used by the predictor
   logic [12:0] cfg_deadband   = fzph_pkg::DEADBAND_RST;
   logic [13:0] cfg_saturation = fzph_pkg::SATURATION_RST;
   logic [11:0] cfg_gain       = fzph_pkg::GAIN_RST;
   logic [15:0] cfg_max_pulse  = fzph_pkg::MAX_PULSE_RST;

   pending_type pending_rsp [$];
   int mismatch_count = 0;
   int dead_words     = 0;
   int fuzzy_words    = 0;
   int sat_words      = 0;
   int settings_count = 0;
   int burst_left     = 0;

   // receiver stall pattern
   int          stall_mode  = 0;
   int          stall_hold  = 0;
   int          stall_phase = 0;
   logic [31:0] stall_bits  = '0;

   fuzzy_ph_pulse_controller dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // triangle or trapezoid grade, Q1.12; flat edges and peaks count as 1.0
   function automatic longint grade_of(longint a, longint b, longint c, longint d,
                                       bit trap, longint v);
      longint g, up, dn;
      g = 0;
      if (!trap) begin
         if (a != b && a < v && v < b) g = (v - a) * GRADE_ONE / (b - a);
         if (b != c && b < v && v < c) g = (c - v) * GRADE_ONE / (c - b);
         if (v == b) g = GRADE_ONE;
      end else begin
         if (v >= b)     up = GRADE_ONE;
         else if (v < a) up = 0;
         else            up = (v - a) * GRADE_ONE / (b - a);
         if (v <= c)     dn = GRADE_ONE;
         else if (v > d) dn = 0;
         else            dn = (d - v) * GRADE_ONE / (d - c);
         g = (up < dn) ? up : dn;
      end
      return g;
   endfunction

   function automatic longint pulse_for_error(longint e);
      longint in_fire [NUM_RULES];
      longint wsum, msum, agg, og, fire, numer, denom, q, steps, gain, maxp;
      steps = NUM_SAMPLES - 1;
      gain  = cfg_gain;
      maxp  = cfg_max_pulse;
      wsum  = 0;
      msum  = 0;
      if (e < 0) e = 0;
      if (e > ERR_TOP) e = ERR_TOP;
      for (int r = 0; r < NUM_RULES; r++)
         in_fire[r] = grade_of(ERR_A[r], ERR_B[r], ERR_C[r], ERR_D[r],
                               r == NUM_RULES - 1, e);
      for (int i = 0; i < NUM_SAMPLES; i++) begin
         agg = 0;
         // sample points at i*100/steps tenths: scale the breakpoints instead
         for (int r = 0; r < NUM_RULES; r++) begin
            og = grade_of(PULSE_A[r] * steps, PULSE_B[r] * steps, PULSE_C[r] * steps,
                          PULSE_D[r] * steps, r == NUM_RULES - 1, i * 100);
            fire = (in_fire[r] < og) ? in_fire[r] : og;
            if (fire > agg) agg = fire;
         end
         wsum += i * agg;
         msum += agg;
      end
      if (msum == 0) return 0;
      numer = wsum * 10 * gain * 1000;
      denom = steps * msum * 256;
      q = (numer * 2 + denom) / (denom * 2);
      if (q > maxp) q = maxp;
      return q;
   endfunction

   function automatic fzph_pkg::rsp_type predict_rsp(fzph_pkg::req_type w);
      fzph_pkg::rsp_type res;
      longint            e, db, sat;
      db  = cfg_deadband;
      sat = cfg_saturation;
      e   = longint'(w.ph_target) - longint'(w.ph_measured);
      if (e <= db) begin
         res.pulse_ms = '0;
         res.zone     = fzph_pkg::ZONE_DEAD;
      end else if (e >= sat) begin
         res.pulse_ms = cfg_max_pulse;
         res.zone     = fzph_pkg::ZONE_SAT;
      end else begin
         res.pulse_ms = 16'(pulse_for_error(e));
         res.zone     = fzph_pkg::ZONE_FUZZY;
      end
      return res;
   endfunction

   function automatic fzph_pkg::req_type word_for_error(longint err);
      fzph_pkg::req_type w;
      if (err > 65535) err = 65535;
      if (err < -65535) err = -65535;
      if (err >= 0) begin
         w.ph_measured = 16'($urandom_range(int'(65535 - err), 0));
         w.ph_target   = w.ph_measured + 16'(err);
      end else begin
         w.ph_target   = 16'($urandom_range(int'(65535 + err), 0));
         w.ph_measured = w.ph_target + 16'(-err);
      end
      return w;
   endfunction

   // mostly fuzzy-zone errors, plus zone edges, raw fields and out-of-range errors
   function automatic fzph_pkg::req_type random_word();
      fzph_pkg::req_type w;
      longint            db, sat, err, lo, hi;
      int                pick;
      bit                raw;
      db   = cfg_deadband;
      sat  = cfg_saturation;
      lo   = db + 1;
      hi   = sat - 1;
      raw  = 1'b0;
      err  = 0;
      pick = $urandom_range(99, 0);
      if (pick < 55 && hi >= lo)
         err = $urandom_range(int'(hi), int'(lo));
      else if (pick < 70) begin
         case ($urandom_range(5, 0))
            0:       err = db;
            1:       err = db + 1;
            2:       err = sat - 1;
            3:       err = sat;
            4:       err = ERR_TOP;
            default: err = ERR_TOP + 1;
         endcase
      end else if (pick < 85)
         raw = 1'b1;
      else if (pick < 93)
         err = -longint'($urandom_range(65535, 1));
      else
         err = $urandom_range(65535, int'(sat));
      if (raw) begin
         w.ph_target   = 16'($urandom);
         w.ph_measured = 16'($urandom);
      end else
         w = word_for_error(err);
      return w;
   endfunction

   task automatic note_mismatch(input string msg);
      mismatch_count++;
      if (mismatch_count <= 10) $display("MISMATCH: %s", msg);
   endtask

   task automatic check_rsp(input fzph_pkg::rsp_type got);
      pending_type entry;
      if (pending_rsp.size() == 0) begin
         note_mismatch($sformatf("result word with none pending: pulse_ms=%0d zone=%0d",
                                 got.pulse_ms, got.zone));
         return;
      end
      entry = pending_rsp.pop_front();
      if (got.pulse_ms !== entry.want.pulse_ms)
         note_mismatch($sformatf("pulse_ms, target=%0d measured=%0d: expected %0d got %0d",
                                 entry.word.ph_target, entry.word.ph_measured,
                                 entry.want.pulse_ms, got.pulse_ms));
      if (got.zone !== entry.want.zone)
         note_mismatch($sformatf("zone, target=%0d measured=%0d: expected %0d got %0d",
                                 entry.word.ph_target, entry.word.ph_measured,
                                 entry.want.zone, got.zone));
   endtask

   // receiver: score each taken word, then pick the next ready value
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) check_rsp(rsp_data);
      if (stall_hold == 0) begin
         stall_mode = $urandom_range(3, 0);
         stall_hold = $urandom_range(300, 20);
         stall_bits = $urandom;
      end else
         stall_hold--;
      stall_phase = (stall_phase + 1) % 32;
      case (stall_mode)
         0:       rsp_ready <= 1'b1;
         1:       rsp_ready <= stall_bits[stall_phase];
         2:       rsp_ready <= ($urandom_range(3, 0) != 0);
         default: rsp_ready <= (stall_phase >= 20);
      endcase
   end

   task automatic send_word(input fzph_pkg::req_type w);
      pending_type entry;
      int          gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(40, 1);
         case ($urandom_range(7, 0))
            0, 1:    gap = 0;
            7:       gap = $urandom_range(150, 20);
            default: gap = $urandom_range(12, 1);
         endcase
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_valid <= 1'b1;
      req_data  <= w;
      do @(posedge clock); while (!req_ready);
      entry.word = w;
      entry.want = predict_rsp(w);
      pending_rsp.push_back(entry);
      case (entry.want.zone)
         fzph_pkg::ZONE_DEAD:  dead_words++;
         fzph_pkg::ZONE_FUZZY: fuzzy_words++;
         default:              sat_words++;
      endcase
   endtask

   // let every pending result come back so the block is idle
   task automatic wait_idle();
      if (req_valid) req_valid <= 1'b0;
      burst_left = 0;
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic apb_cycle(input bit is_write, input logic [1:0] idx,
                            input logic [fzph_pkg::PDATA_W-1:0] data,
                            output logic [fzph_pkg::PDATA_W-1:0] rdata);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= is_write;
      paddr   <= {idx, 2'b00};
      pwdata  <= data;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      rdata = prdata;
   endtask

   task automatic bus_idle();
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   function automatic logic [fzph_pkg::PDATA_W-1:0] reg_model(logic [1:0] idx);
      case (idx)
         fzph_pkg::REG_DEADBAND:   return fzph_pkg::PDATA_W'(cfg_deadband);
         fzph_pkg::REG_SATURATION: return fzph_pkg::PDATA_W'(cfg_saturation);
         fzph_pkg::REG_GAIN:       return fzph_pkg::PDATA_W'(cfg_gain);
         default:                  return fzph_pkg::PDATA_W'(cfg_max_pulse);
      endcase
   endfunction

   task automatic reg_write(input logic [1:0] idx,
                            input logic [fzph_pkg::PDATA_W-1:0] value);
      logic [fzph_pkg::PDATA_W-1:0] unused;
      apb_cycle(1'b1, idx, value, unused);
      case (idx)
         fzph_pkg::REG_DEADBAND:   cfg_deadband   = value[12:0];
         fzph_pkg::REG_SATURATION: cfg_saturation = value[13:0];
         fzph_pkg::REG_GAIN:       cfg_gain       = value[11:0];
         default:                  cfg_max_pulse  = value[15:0];
      endcase
   endtask

   task automatic reg_check(input logic [1:0] idx);
      logic [fzph_pkg::PDATA_W-1:0] got;
      apb_cycle(1'b0, idx, '0, got);
      if (got !== reg_model(idx))
         note_mismatch($sformatf("register %0d read: expected %0d got %0d",
                                 idx, reg_model(idx), got));
   endtask

   task automatic set_config(input int unsigned db, sat, gain, maxp);
      wait_idle();
      reg_write(fzph_pkg::REG_DEADBAND, db);
      reg_write(fzph_pkg::REG_SATURATION, sat);
      reg_write(fzph_pkg::REG_GAIN, gain);
      reg_write(fzph_pkg::REG_MAX_PULSE, maxp);
      reg_check(fzph_pkg::REG_DEADBAND);
      reg_check(fzph_pkg::REG_SATURATION);
      reg_check(fzph_pkg::REG_GAIN);
      reg_check(fzph_pkg::REG_MAX_PULSE);
      bus_idle();
      settings_count++;
   endtask

   task automatic test_register_defaults();
      reg_check(fzph_pkg::REG_DEADBAND);
      reg_check(fzph_pkg::REG_SATURATION);
      reg_check(fzph_pkg::REG_GAIN);
      reg_check(fzph_pkg::REG_MAX_PULSE);
      bus_idle();
   endtask

   // field extremes, negative error and the zone edges at reset settings
   task automatic test_field_extremes();
      send_word('{16'h0000, 16'h0000});
      send_word('{16'hFFFF, 16'hFFFF});
      send_word('{16'hFFFF, 16'h0000});
      send_word('{16'h0000, 16'hFFFF});
      send_word('{16'hE000, 16'h0000});
      send_word(word_for_error(410));
      send_word(word_for_error(411));
      send_word(word_for_error(3276));
   endtask

   // set edges and peaks, plus an error past the top of the universe
   task automatic test_set_edges();
      int edges [11] = '{1, 246, 614, 1147, 1434, 2048, 2376, 2662, 3072, 3277, 9000};
      set_config(0, 16383, 512, 20000);
      foreach (edges[k]) send_word(word_for_error(edges[k]));
   endtask

   // dead band test wins when saturation sits below it
   task automatic test_saturation_below_deadband();
      set_config(4096, 100, 512, 20000);
      send_word(word_for_error(100));
      send_word(word_for_error(4096));
      send_word(word_for_error(4097));
   endtask

   task automatic test_gain_and_clamp();
      set_config(0, 16383, 4095, 1234);
      send_word(word_for_error(3277));
      send_word(word_for_error(1434));
      set_config(0, 16383, 0, 65535);
      send_word(word_for_error(2048));
   endtask

   task automatic test_random_phase(input int unsigned db, sat, gain, maxp, input int n);
      set_config(db, sat, gain, maxp);
      repeat (n) send_word(random_word());
   endtask

   task automatic test_random_config(input int n);
      int unsigned db, sat;
      db  = $urandom_range(1500, 0);
      sat = $urandom_range(4200, db + 1);
      test_random_phase(db, sat, $urandom_range(4095, 0), $urandom_range(65535, 0), n);
   endtask

   initial begin
      reset     = 1'b1;
      req_valid = 1'b0;
      req_data  = '0;
      psel      = 1'b0;
      penable   = 1'b0;
      pwrite    = 1'b0;
      paddr     = '0;
      pwdata    = '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      test_register_defaults();
      test_field_extremes();
      test_set_edges();
      test_saturation_below_deadband();
      test_gain_and_clamp();
      test_random_phase(fzph_pkg::DEADBAND_RST, fzph_pkg::SATURATION_RST,
                        fzph_pkg::GAIN_RST, fzph_pkg::MAX_PULSE_RST, 250);
      test_random_phase(0, 8192, 4095, 65535, 250);
      test_random_phase(8191, 16383, 4095, 65535, 100);
      test_random_phase(0, 0, 0, 0, 50);
      repeat (4) test_random_config(150);

      wait_idle();
      repeat (100) @(posedge clock);
      if (pending_rsp.size() != 0)
         note_mismatch($sformatf("%0d results never arrived", pending_rsp.size()));
      $display("Run covered %0d words: %0d dead band, %0d fuzzy, %0d saturated",
               dead_words + fuzzy_words + sat_words, dead_words, fuzzy_words, sat_words);
      $display("across %0d register settings; %0d mismatches seen", settings_count,
               mismatch_count);
      if (mismatch_count == 0)
         $display("fuzzy_ph_pulse_controller verification clean");
      else
         $display("fuzzy_ph_pulse_controller verification failed");
      $finish;
   end

   initial begin
      #100_000_000;
      $display("run exceeded its time limit");
      $display("fuzzy_ph_pulse_controller verification failed");
      $finish;
   end

endmodule

`default_nettype wire
